// ----- sv/pfcrc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfcrc_pkg
// constants, item codes and the crc byte update shared by the packet framer
// ----------------------------------------------------------------------------
package pfcrc_pkg;

    localparam int LEN_W  = 7;
    localparam int STEP_W = 3;

    localparam logic [7:0]       SYNC_FIRST  = 8'hEB;
    localparam logic [7:0]       SYNC_SECOND = 8'hA6;
    localparam logic [15:0]      CRC_INIT    = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY    = 16'hA001;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 7'd119;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    localparam logic [STEP_W-1:0] STEP_SYNC1  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SYNC2  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ZERO   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LEN_LO = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LEN_HI = 3'd4;
    localparam logic [STEP_W-1:0] STEP_HCRC_LO = 3'd5;
    localparam logic [STEP_W-1:0] STEP_HCRC_HI = 3'd6;
    localparam logic [STEP_W-1:0] STEP_BYTE    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DCRC_LO = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DCRC_HI = 3'd2;

    typedef enum logic [1:0] {
        ITEM_ERR   = 2'd0,
        ITEM_START = 2'd1,
        ITEM_DATA  = 2'd2
    } item_class_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/packet_framer_crc16_modbus.sv -----
// ----------------------------------------------------------------------------
// packet_framer_crc16_modbus
// wraps a byte payload into a packet with sync header, length and crc-16/modbus
// ----------------------------------------------------------------------------
// input transfers are either a start (tuser 0, tdata carries the length) or a
// payload byte (tuser 1). a start produces the five header bytes eb a6 00
// len+2 (little endian); a zero length also appends the crc at once. each
// payload byte is passed on, and the last one is followed by the crc, low
// byte first, with frame_end set on the final crc byte. a start inside an
// open frame or a byte with no open frame gives one error transfer.
// every output transfer leaves one byte, one per cycle unless the receiver
// stalls: a start gives 5 or 7 bytes, a payload byte 1 or 3, an error 1. one
// input register holds the item being sent, so a new item is taken in the cycle
// its last byte moves to the output register, which presents each byte.
// a stalled receiver holds the output register and, behind it, the held
// item; the input side stalls once both are full.
// reset empties both registers, closes any frame and reloads the crc.
// ----------------------------------------------------------------------------
module packet_framer_crc16_modbus (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // payload_length[6:0], data_byte[14:7], zero pad
    input  logic [0:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast,   // run_last
    output logic [1:0]  m_axis_tuser    // frame_end, error
);
    import pfcrc_pkg::*;

    logic              hold_valid_reg;
    logic              hold_kind_reg;
    logic [LEN_W-1:0]  hold_len_reg;
    logic [7:0]        hold_byte_reg;
    logic [STEP_W-1:0] step_reg;

    logic [15:0]       crc_reg;
    logic [LEN_W-1:0]  remaining_reg;
    logic              open_reg;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_fend_reg;
    logic              out_err_reg;

    item_class_t       cls;
    logic [LEN_W-1:0]  in_len;
    logic [LEN_W-1:0]  sat_len;
    logic [15:0]       hdr_len;
    logic              close_run;
    logic [7:0]        res_byte;
    logic              res_last;
    logic              res_fend;
    logic              res_err;
    logic              res_feed;
    logic [15:0]       crc_base;
    logic              emit;
    logic              s_fire;

    assign in_len  = s_axis_tdata[LEN_W-1:0];
    assign sat_len = (in_len > MAX_PAYLOAD) ? MAX_PAYLOAD : in_len;
    assign hdr_len = {{(16-LEN_W){1'b0}}, hold_len_reg} + 16'd2;

    always_comb begin
        if (hold_kind_reg == KIND_START) begin
            cls = open_reg ? ITEM_ERR : ITEM_START;
        end else begin
            cls = open_reg ? ITEM_DATA : ITEM_ERR;
        end
    end

    assign close_run = ((cls == ITEM_START) && (hold_len_reg == '0)) ||
                       ((cls == ITEM_DATA) && (remaining_reg == {{(LEN_W-1){1'b0}}, 1'b1}));

    always_comb begin
        res_byte = 8'h00;
        res_last = 1'b0;
        res_fend = 1'b0;
        res_err  = 1'b0;
        res_feed = 1'b0;
        unique case (cls)
            ITEM_ERR: begin
                res_last = 1'b1;
                res_err  = 1'b1;
            end
            ITEM_START: begin
                priority if (step_reg == STEP_SYNC1) begin
                    res_byte = SYNC_FIRST;
                    res_feed = 1'b1;
                end else if (step_reg == STEP_SYNC2) begin
                    res_byte = SYNC_SECOND;
                    res_feed = 1'b1;
                end else if (step_reg == STEP_ZERO) begin
                    res_byte = 8'h00;
                    res_feed = 1'b1;
                end else if (step_reg == STEP_LEN_LO) begin
                    res_byte = hdr_len[7:0];
                    res_feed = 1'b1;
                end else if (step_reg == STEP_LEN_HI) begin
                    res_byte = hdr_len[15:8];
                    res_feed = 1'b1;
                    res_last = !close_run;
                end else if (step_reg == STEP_HCRC_LO) begin
                    res_byte = crc_reg[7:0];
                end else begin
                    res_byte = crc_reg[15:8];
                    res_last = 1'b1;
                    res_fend = 1'b1;
                end
            end
            ITEM_DATA: begin
                priority if (step_reg == STEP_BYTE) begin
                    res_byte = hold_byte_reg;
                    res_feed = 1'b1;
                    res_last = !close_run;
                end else if (step_reg == STEP_DCRC_LO) begin
                    res_byte = crc_reg[7:0];
                end else begin
                    res_byte = crc_reg[15:8];
                    res_last = 1'b1;
                    res_fend = 1'b1;
                end
            end
            default: begin
                res_last = 1'b1;
                res_err  = 1'b1;
            end
        endcase
    end

    assign crc_base = ((cls == ITEM_START) && (step_reg == STEP_SYNC1)) ? CRC_INIT : crc_reg;

    assign emit          = hold_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !hold_valid_reg || (emit && res_last);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // held item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            step_reg       <= '0;
        end else begin
            if (s_fire) begin
                hold_valid_reg <= 1'b1;
            end else if (emit && res_last) begin
                hold_valid_reg <= 1'b0;
            end
            if (emit) begin
                step_reg <= res_last ? '0 : step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hold_kind_reg <= s_axis_tuser[0];
            hold_len_reg  <= sat_len;
            hold_byte_reg <= s_axis_tdata[LEN_W+7:LEN_W];
        end
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_INIT;
            remaining_reg <= '0;
            open_reg      <= 1'b0;
        end else if (emit) begin
            if (res_fend) begin
                crc_reg       <= CRC_INIT;
                remaining_reg <= '0;
                open_reg      <= 1'b0;
            end else begin
                if (res_feed) begin
                    crc_reg <= crc_feed(crc_base, res_byte);
                end
                if (res_last && (cls == ITEM_START)) begin
                    remaining_reg <= hold_len_reg;
                    open_reg      <= 1'b1;
                end else if (res_last && (cls == ITEM_DATA)) begin
                    remaining_reg <= remaining_reg - 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
            out_fend_reg <= res_fend;
            out_err_reg  <= res_err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_err_reg, out_fend_reg};

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the crc-16/modbus packet framer
// ----------------------------------------------------------------------------
// a queue of start and payload items is fed through the input stream with
// random gaps. every accepted item is run through a bench-side framer that
// predicts the header, passed bytes, crc and error transfers. the output
// stream is checked in order against these predictions, with random and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import pfcrc_pkg::*;

    typedef struct packed {
        logic             kind;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        logic             drain;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       frame_end;
        logic       error;
    } packet_byte_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // payload_length[6:0], data_byte[14:7], zero pad
    logic [0:0]  s_axis_tuser  = '0;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // out_byte
    logic        m_axis_tlast;         // run_last
    logic [1:0]  m_axis_tuser;         // frame_end, error

    frame_item_t  item_q[$];
    packet_byte_t packet_q[$];
    frame_item_t  cur_item;

    // bench-side framer state
    logic [15:0]      crc_acc    = CRC_INIT;
    logic [LEN_W-1:0] bytes_left = '0;
    logic             in_frame   = 1'b0;

    int mismatch_cnt  = 0;
    int items_sent    = 0;
    int bytes_checked = 0;
    int frames_closed = 0;
    int errors_seen   = 0;
    int tx_gap        = 0;
    int rx_stall      = 0;
    int hold_left     = 0;
    logic hold_done   = 1'b0;
    logic hold_on;

    packet_framer_crc16_modbus dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic void push_result(input logic [7:0] value, input logic last,
                                        input logic fend, input logic err);
        packet_byte_t p;
        p.value     = value;
        p.run_last  = last;
        p.frame_end = fend;
        p.error     = err;
        packet_q.push_back(p);
    endfunction

    function automatic void emit_byte(input logic [7:0] value, input logic last);
        push_result(value, last, 1'b0, 1'b0);
        crc_acc = modbus_crc_step(crc_acc, value);
    endfunction

    function automatic void close_frame();
        push_result(crc_acc[7:0], 1'b0, 1'b0, 1'b0);
        push_result(crc_acc[15:8], 1'b1, 1'b1, 1'b0);
        crc_acc    = CRC_INIT;
        bytes_left = '0;
        in_frame   = 1'b0;
        frames_closed++;
    endfunction

    function automatic void frame_predict(input frame_item_t it);
        logic [LEN_W-1:0] n;
        logic [15:0]      hlen;
        if (it.kind == KIND_START) begin
            if (in_frame) begin
                push_result(8'h00, 1'b1, 1'b0, 1'b1);
                errors_seen++;
                return;
            end
            n    = (it.len > MAX_PAYLOAD) ? MAX_PAYLOAD : it.len;
            hlen = {9'd0, n} + 16'd2;
            crc_acc = CRC_INIT;
            emit_byte(SYNC_FIRST, 1'b0);
            emit_byte(SYNC_SECOND, 1'b0);
            emit_byte(8'h00, 1'b0);
            emit_byte(hlen[7:0], 1'b0);
            emit_byte(hlen[15:8], n != '0);
            if (n == '0) begin
                close_frame();
            end else begin
                bytes_left = n;
                in_frame   = 1'b1;
            end
        end else begin
            if (!in_frame) begin
                push_result(8'h00, 1'b1, 1'b0, 1'b1);
                errors_seen++;
                return;
            end
            bytes_left = bytes_left - 1'b1;
            emit_byte(it.data, bytes_left != '0);
            if (bytes_left == '0)
                close_frame();
        end
    endfunction

    function automatic void add_item(input logic kind, input logic [LEN_W-1:0] len,
                                     input logic [7:0] data);
        frame_item_t it;
        it.kind  = kind;
        it.len   = len;
        it.data  = data;
        it.drain = (item_q.size() % 100 == 50);
        item_q.push_back(it);
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 65)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    function automatic void report_mismatch(input string what, input packet_byte_t want,
                                            input packet_byte_t got);
        if (mismatch_cnt < 10) begin
            $write("mismatch (%s) at %0t: expected byte %02h last %0b end %0b err %0b,",
                   what, $realtime, want.value, want.run_last, want.frame_end, want.error);
            $display(" got byte %02h last %0b end %0b err %0b",
                     got.value, got.run_last, got.frame_end, got.error);
        end
        mismatch_cnt++;
    endfunction

    // input side
    always @(posedge aclk) begin
        logic load;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                frame_predict(cur_item);
                items_sent <= items_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                load = 1'b0;
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (item_q.size() != 0 &&
                             !(item_q[0].drain && packet_q.size() != 0)) begin
                    cur_item = item_q.pop_front();
                    s_axis_tdata <= {1'b0, cur_item.data, cur_item.len};
                    s_axis_tuser <= cur_item.kind;
                    load = 1'b1;
                    tx_gap = ((items_sent / 64) % 4 == 3) ? 0 : pick_gap();
                end
                s_axis_tvalid <= load;
            end
        end
    end

    // one long receiver hold-off while the sender keeps offering
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_sent >= 120) begin
            hold_done <= 1'b1;
            hold_left <= 300;
        end
    end

    assign hold_on = (hold_left != 0);

    // output side ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_stall <= 0;
        end else if (hold_on) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if ((bytes_checked / 80) % 4 == 1) begin
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_stall <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // output checker
    always @(posedge aclk) begin
        packet_byte_t want;
        packet_byte_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.value     = m_axis_tdata;
            got.run_last  = m_axis_tlast;
            got.frame_end = m_axis_tuser[0];
            got.error     = m_axis_tuser[1];
            bytes_checked <= bytes_checked + 1;
            if (packet_q.size() == 0) begin
                want = '0;
                report_mismatch("unexpected transfer", want, got);
            end else begin
                want = packet_q.pop_front();
                if (got.value !== want.value || got.run_last !== want.run_last ||
                    got.frame_end !== want.frame_end || got.error !== want.error)
                    report_mismatch("field", want, got);
            end
        end
    end

    initial begin
        int built;
        int frame_no;
        int nbytes;
        int cut;
        int waited;
        logic [LEN_W-1:0] len;

        // directed: stray byte, zero length, short frames, start inside a frame
        add_item(KIND_DATA, 7'd0, 8'hFF);
        add_item(KIND_START, 7'd0, 8'h00);
        add_item(KIND_START, 7'd1, 8'hFF);
        add_item(KIND_DATA, 7'd127, 8'h00);
        add_item(KIND_START, 7'd2, 8'h00);
        add_item(KIND_DATA, 7'd0, 8'hFF);
        add_item(KIND_START, 7'd5, 8'h3C);
        add_item(KIND_DATA, 7'd127, 8'h80);
        add_item(KIND_START, 7'd3, 8'hFF);
        add_item(KIND_DATA, 7'd1, 8'h01);
        add_item(KIND_DATA, 7'd64, 8'h7F);
        add_item(KIND_DATA, 7'd0, 8'hAA);
        add_item(KIND_START, 7'd0, 8'hFF);
        add_item(KIND_DATA, 7'd127, 8'h55);

        // random frames with some noise and truncated frames
        built    = 0;
        frame_no = 0;
        while (built < 450) begin
            if ($urandom_range(0, 11) == 0)
                add_item(KIND_DATA, LEN_W'($urandom_range(0, 127)),
                         8'($urandom_range(0, 255)));
            if (frame_no == 2)
                len = 7'd127;
            else if (frame_no == 7)
                len = MAX_PAYLOAD;
            else if ($urandom_range(0, 99) < 85)
                len = LEN_W'($urandom_range(0, 12));
            else
                len = LEN_W'($urandom_range(13, 127));
            add_item(KIND_START, len, 8'($urandom_range(0, 255)));
            built++;
            nbytes = int'((len > MAX_PAYLOAD) ? MAX_PAYLOAD : len);
            if (nbytes > 1 && $urandom_range(0, 19) == 0)
                cut = int'($urandom_range(1, nbytes - 1));
            else
                cut = nbytes;
            for (int j = 0; j < cut; j++) begin
                if ($urandom_range(0, 24) == 0)
                    add_item(KIND_START, LEN_W'($urandom_range(0, 127)),
                             8'($urandom_range(0, 255)));
                add_item(KIND_DATA, LEN_W'($urandom_range(0, 127)),
                         8'($urandom_range(0, 255)));
                built++;
            end
            frame_no++;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (item_q.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        waited = 0;
        while (packet_q.size() != 0 && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (30) @(posedge aclk);

        if (packet_q.size() != 0) begin
            if (mismatch_cnt < 10)
                $display("%0d expected output transfers never arrived", packet_q.size());
            mismatch_cnt += packet_q.size();
        end

        $display("ran %0d input transfers: %0d frames closed, %0d out-of-sequence items",
                 items_sent, frames_closed, errors_seen);
        $display("checked %0d output transfers, with random and one 300-cycle output stall",
                 bytes_checked);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
